[hdl/vlist_pkg.sv]
// ----------------------------------------------------------------------------
// vlist_pkg
// Types and codes shared by the value list controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlist_pkg;

  localparam int MAX_RESULTS = 32;

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_REAR  = 3'd1;
  localparam logic [2:0] KIND_DEL_FRONT = 3'd2;
  localparam logic [2:0] KIND_DEL_REAR  = 3'd3;
  localparam logic [2:0] KIND_DEL_VALUE = 3'd4;
  localparam logic [2:0] KIND_DUMP      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [4:0]         position;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_INS_FRONT,
    DP_INS_REAR,
    DP_DEL_FRONT,
    DP_DEL_REAR,
    DP_LOAD,
    DP_SEARCH,
    DP_SHIFT_START,
    DP_SHIFT,
    DP_DEL_DONE,
    DP_DUMP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic miss_end;
    logic walk_end;
    logic dump_end;
  } sts_t;

endpackage

`default_nettype wire

[hdl/vlist_ctrl.sv]
// ----------------------------------------------------------------------------
// vlist_ctrl
// Command sequencer: decodes requests and steps search, shift and dump walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlist_ctrl
  import vlist_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DUMP   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd.op          = DP_NONE;
    cmd.emit        = 1'b0;
    cmd.emit_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.emit = 1'b1;
          unique case (req.kind)
            KIND_INS_FRONT, KIND_INS_REAR: begin
              if (sts.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.op = (req.kind == KIND_INS_FRONT) ? DP_INS_FRONT : DP_INS_REAR;
              end
            end
            KIND_DEL_FRONT, KIND_DEL_REAR: begin
              if (sts.empty) begin
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.op = (req.kind == KIND_DEL_FRONT) ? DP_DEL_FRONT : DP_DEL_REAR;
              end
            end
            KIND_DEL_VALUE, KIND_DUMP: begin
              if (sts.empty) begin
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.emit   = 1'b0;
                cmd.op     = DP_LOAD;
                state_next = (req.kind == KIND_DUMP) ? S_DUMP : S_SEARCH;
              end
            end
            default: begin
              cmd.emit_status = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.op     = DP_SHIFT_START;
          state_next = S_SHIFT;
        end else if (sts.miss_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOTFOUND;
          state_next      = S_IDLE;
        end else begin
          cmd.op = DP_SEARCH;
        end
      end
      S_SHIFT: begin
        if (sts.walk_end) begin
          cmd.op     = DP_DEL_DONE;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op = DP_SHIFT;
        end
      end
      S_DUMP: begin
        cmd.op = DP_DUMP;
        if (sts.dump_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/vlist_dp.sv]
// ----------------------------------------------------------------------------
// vlist_dp
// List datapath: circular entry store, head and count, read pipeline, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlist_dp
  import vlist_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      strobe,
  output rsp_t      rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DUMP_MAX = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
  localparam logic [CW:0]   CAP_X      = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_W      = CW'(CAPACITY);
  localparam logic [CW-1:0] DUMP_MAX_W = CW'(DUMP_MAX);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
                                             input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(l);
    return (s >= CAP_X) ? AW'(s - CAP_X) : AW'(s);
  endfunction

  logic [31:0]   mem [CAPACITY];
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          pend_vld, pend_vld_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic [31:0]   rdata;
  logic [31:0]   value_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [AW-1:0] head_m1;
  logic [CW-1:0] dump_n;
  logic [CW-1:0] pend_ext;
  logic          issue_walk;
  logic          issue_dump;
  logic          dump_out;

  assign head_m1    = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign dump_n     = (count > DUMP_MAX_W) ? DUMP_MAX_W : count;
  assign pend_ext   = CW'(pend_idx);
  assign issue_walk = (rd_idx < count);
  assign issue_dump = (rd_idx < dump_n);
  assign raddr      = wrap_add(head, rd_idx);
  assign dump_out   = (cmd.op == DP_DUMP) && pend_vld;

  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CAP_W);
  assign sts.hit      = pend_vld && (rdata == value_q);
  assign sts.miss_end = pend_vld && (rdata != value_q) && (pend_ext == count - CW'(1));
  assign sts.walk_end = !pend_vld && (rd_idx >= count);
  assign sts.dump_end = pend_vld && (pend_ext == dump_n - CW'(1));

  always_comb begin
    head_next     = head;
    count_next    = count;
    rd_idx_next   = rd_idx;
    pend_vld_next = 1'b0;
    pend_idx_next = rd_idx[AW-1:0];
    we            = 1'b0;
    waddr         = wrap_add(head, pend_ext - CW'(1));
    wdata         = rdata;
    re            = 1'b0;
    unique case (cmd.op)
      DP_INS_FRONT: begin
        we         = 1'b1;
        waddr      = head_m1;
        wdata      = req.value;
        head_next  = head_m1;
        count_next = count + CW'(1);
      end
      DP_INS_REAR: begin
        we         = 1'b1;
        waddr      = wrap_add(head, count);
        wdata      = req.value;
        count_next = count + CW'(1);
      end
      DP_DEL_FRONT: begin
        head_next  = (head == LAST_SLOT) ? '0 : head + AW'(1);
        count_next = count - CW'(1);
      end
      DP_DEL_REAR, DP_DEL_DONE: begin
        count_next = count - CW'(1);
      end
      DP_LOAD: begin
        rd_idx_next = '0;
      end
      DP_SEARCH: begin
        re            = issue_walk;
        pend_vld_next = issue_walk;
        if (issue_walk) begin
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      DP_SHIFT_START: begin
        rd_idx_next = pend_ext + CW'(1);
      end
      DP_SHIFT: begin
        we            = pend_vld;
        re            = issue_walk;
        pend_vld_next = issue_walk;
        if (issue_walk) begin
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      DP_DUMP: begin
        re            = issue_dump;
        pend_vld_next = issue_dump;
        if (issue_dump) begin
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      default: begin
        pend_vld_next = 1'b0;
      end
    endcase
  end

  // entry store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rd_idx   <= '0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      rd_idx   <= rd_idx_next;
      pend_vld <= pend_vld_next;
      strobe   <= cmd.emit || dump_out;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    if (cmd.op == DP_LOAD) begin
      value_q <= req.value;
    end
    if (dump_out) begin
      rsp.status   <= ST_OK;
      rsp.element  <= rdata;
      rsp.position <= 5'(pend_idx);
      rsp.last     <= sts.dump_end;
    end else begin
      rsp.status   <= cmd.emit_status;
      rsp.element  <= '0;
      rsp.position <= '0;
      rsp.last     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/value_list_with_delete_by_value.sv]
// quick requests: front/rear insert and delete, undefined kinds and requests on an empty list
//   answer in the cycle after the request and never raise busy
// delete by value: the search and then the shift behind the match take one entry per cycle;
//   busy falls as the result is strobed
// dump: up to 32 elements from the front, one per cycle, with busy falling as the last one
//   is strobed; reset clears head, occupancy, read state, strobe and the controller only
// ----------------------------------------------------------------------------
// value_list_with_delete_by_value
// Bounded ordered list of signed values with front/rear insert and delete,
// delete by value and dump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module value_list_with_delete_by_value
  import vlist_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      strobe,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  vlist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  vlist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .rsp    (rsp)
  );

  // front/rear insert and delete answer in the cycle after the request
  a_quick_result : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.kind == KIND_INS_FRONT || req.kind == KIND_INS_REAR ||
      req.kind == KIND_DEL_FRONT || req.kind == KIND_DEL_REAR))
    |=> (strobe && rsp.last))
    else $error("missing result for single-cycle request");

  // leaving a walk always delivers the closing result
  a_walk_close : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && rsp.last))
    else $error("walk ended without final result");

  // error results carry no element
  a_error_clean : assert property (@(posedge clk) disable iff (rst)
    (strobe && rsp.status != ST_OK) |-> (rsp.element == '0 && rsp.last))
    else $error("error result with element data");

  // no result while idle without a request or a walk in the previous cycle
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(start) && !$past(busy)) |-> !strobe)
    else $error("unexpected result");

endmodule

`default_nettype wire

[test/value_list_with_delete_by_value_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_list_with_delete_by_value_tb
// Self-checking bench for the bounded value list. A driver sends requests
// from a pending queue, with random idle bursts. A shadow list works out the
// responses of each accepted request. A monitor compares every strobed
// response with the oldest one still due. Stimulus starts with empty-list,
// extreme-value and duplicate cases. Random phases then fill the list past
// full and drain it past empty.
// ----------------------------------------------------------------------------
module value_list_with_delete_by_value_tb;
  import vlist_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int CLK_HALF = 2;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [2:0] KIND_UNDEF_A = 3'd6;
  localparam logic [2:0] KIND_UNDEF_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic strobe;
  rsp_t rsp;

  req_t cmd_pending[$];
  logic signed [31:0] list_shadow[$];
  rsp_t rsp_due[$];
  int cmds_total = 0;
  int cmds_taken = 0;
  int gap_left = 0;
  int mismatches = 0;

  value_list_with_delete_by_value #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .strobe(strobe),
    .rsp(rsp)
  );

  always #CLK_HALF clk = ~clk;

  task automatic apply_list_command(input req_t r);
    rsp_t e;
    int n;
    e = '0;
    e.status = ST_OK;
    e.last = 1'b1;
    case (r.kind)
      KIND_INS_FRONT, KIND_INS_REAR: begin
        if (list_shadow.size() >= LIST_DEPTH) e.status = ST_FULL;
        else if (r.kind == KIND_INS_FRONT) list_shadow.push_front(r.value);
        else list_shadow.push_back(r.value);
      end
      KIND_DEL_FRONT: begin
        if (list_shadow.size() == 0) e.status = ST_EMPTY;
        else void'(list_shadow.pop_front());
      end
      KIND_DEL_REAR: begin
        if (list_shadow.size() == 0) e.status = ST_EMPTY;
        else void'(list_shadow.pop_back());
      end
      KIND_DEL_VALUE: begin
        if (list_shadow.size() == 0) begin
          e.status = ST_EMPTY;
        end else begin
          e.status = ST_NOTFOUND;
          for (int i = 0; i < list_shadow.size(); i++) begin
            if (list_shadow[i] == r.value) begin
              list_shadow.delete(i);
              e.status = ST_OK;
              break;
            end
          end
        end
      end
      KIND_DUMP: begin
        if (list_shadow.size() == 0) begin
          e.status = ST_EMPTY;
        end else begin
          n = (list_shadow.size() < MAX_RESULTS) ? list_shadow.size() : MAX_RESULTS;
          for (int i = 0; i < n; i++) begin
            e.element = list_shadow[i];
            e.position = 5'(i);
            e.last = (i == n - 1);
            rsp_due.push_back(e);
          end
          return;
        end
      end
      default: ;
    endcase
    rsp_due.push_back(e);
  endtask

  task automatic queue_cmd(input logic [2:0] k, input logic signed [31:0] v);
    req_t r;
    r.kind = k;
    r.value = v;
    cmd_pending.push_back(r);
    cmds_total++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_list_command(req);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_pending.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_pending.size() > 25 && (cmd_pending.size() / 20) % 3 != 0 &&
                     $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          start <= 1'b0;
        end else begin
          req <= cmd_pending.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    rsp_t due;
    if (!rst && strobe) begin
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: status %0d element %0d position %0d last %0d",
                   rsp.status, rsp.element, rsp.position, rsp.last);
      end else begin
        due = rsp_due.pop_front();
        if (rsp.status !== due.status || rsp.element !== due.element ||
            rsp.position !== due.position || rsp.last !== due.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"response mismatch: exp status %0d element %0d position %0d last %0d,",
                      " got status %0d element %0d position %0d last %0d"},
                     due.status, due.element, due.position, due.last,
                     rsp.status, rsp.element, rsp.position, rsp.last);
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] seen[$];
    logic signed [31:0] v;
    logic [2:0] k;
    int roll;

    // empty list, undefined kinds, extremes, duplicates, head/rear matches
    queue_cmd(KIND_DUMP, $urandom);
    queue_cmd(KIND_DEL_FRONT, $urandom);
    queue_cmd(KIND_DEL_REAR, $urandom);
    queue_cmd(KIND_DEL_VALUE, 32'sd7);
    queue_cmd(KIND_UNDEF_A, $urandom);
    queue_cmd(KIND_UNDEF_B, $urandom);
    queue_cmd(KIND_INS_FRONT, 32'sh7fffffff);
    queue_cmd(KIND_INS_REAR, 32'sh80000000);
    queue_cmd(KIND_INS_REAR, 32'sd0);
    queue_cmd(KIND_INS_FRONT, -32'sd1);
    queue_cmd(KIND_INS_REAR, 32'sd5);
    queue_cmd(KIND_INS_REAR, 32'sd5);
    queue_cmd(KIND_DUMP, $urandom);
    queue_cmd(KIND_DEL_VALUE, 32'sd1234);
    queue_cmd(KIND_DEL_VALUE, -32'sd1);
    queue_cmd(KIND_DEL_VALUE, 32'sd5);
    queue_cmd(KIND_DEL_VALUE, 32'sd5);
    queue_cmd(KIND_DEL_FRONT, $urandom);
    queue_cmd(KIND_DEL_REAR, $urandom);
    queue_cmd(KIND_DUMP, $urandom);
    queue_cmd(KIND_DEL_VALUE, 32'sh80000000);
    queue_cmd(KIND_INS_FRONT, 32'sd3);
    queue_cmd(KIND_DEL_VALUE, 32'sd3);

    // alternate fill and drain phases
    for (int phase = 0; phase < 4; phase++) begin
      for (int j = 0; j < 37; j++) begin
        roll = $urandom_range(0, 99);
        if (phase % 2 == 0) begin
          if (roll < 90) k = $urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_REAR;
          else if (roll < 95) k = KIND_DUMP;
          else if (roll < 98) k = 3'($urandom_range(KIND_DEL_FRONT, KIND_DEL_VALUE));
          else k = $urandom_range(0, 1) ? KIND_UNDEF_A : KIND_UNDEF_B;
        end else begin
          if (roll < 25) k = KIND_DEL_FRONT;
          else if (roll < 45) k = KIND_DEL_REAR;
          else if (roll < 82) k = KIND_DEL_VALUE;
          else if (roll < 90) k = KIND_DUMP;
          else if (roll < 97) k = $urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_REAR;
          else k = $urandom_range(0, 1) ? KIND_UNDEF_A : KIND_UNDEF_B;
        end
        roll = $urandom_range(0, 99);
        if (k == KIND_DEL_VALUE && roll < 70 && seen.size() > 0) begin
          v = seen[$urandom_range(0, seen.size() - 1)];
        end else if (roll < 25) begin
          v = $urandom_range(0, 6);
          v = v - 3;
        end else if (roll < 35) begin
          case ($urandom_range(0, 3))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end else begin
          v = $urandom;
        end
        if (k == KIND_INS_FRONT || k == KIND_INS_REAR) begin
          seen.push_back(v);
          if (seen.size() > 16) void'(seen.pop_front());
        end
        queue_cmd(k, v);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmds_taken < cmds_total) @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
